// File: hw/rtl/first_fit_segment_write_tracker_defines.svh
// Assertion macros shared by the segment write tracker RTL.
`ifndef FIRST_FIT_SEGMENT_WRITE_TRACKER_DEFINES_SVH
`define FIRST_FIT_SEGMENT_WRITE_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFSWT_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFSWT_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/ffswt_pkg.sv
// Package with the word types and fixed constants of the segment write tracker.
`timescale 1ns / 1ps
`default_nettype none
package ffswt_pkg;

  // Map words hold 64 byte-valid bits.
  localparam int MAP_WORD_W = 64;
  localparam int BIT_IDX_W  = 6;
  // Bits newly set in one map word: 0 to 64.
  localparam int ADDED_W    = 7;
  // Width of a fill count plus a byte count before the capacity compare.
  localparam int SUM_W      = 17;

  // Input word: one write request.
  typedef struct packed {
    logic [15:0] byte_offset;
    logic [15:0] byte_count;
  } in_t;

  // Result word.
  typedef struct packed {
    logic        status;
    logic [9:0]  segment_index;
    logic [10:0] fill_after;
  } out_t;

  // Status codes.
  localparam logic STATUS_WRITTEN  = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  // Bit range inside the current map word that the request covers.
  typedef struct packed {
    logic [BIT_IDX_W-1:0] lo;
    logic [BIT_IDX_W-1:0] hi;
  } wu_req_t;

  // Updated map word and the number of bits that were newly set.
  typedef struct packed {
    logic [MAP_WORD_W-1:0] word;
    logic [ADDED_W-1:0]    added;
  } wu_res_t;

endpackage
`default_nettype wire

// File: hw/rtl/ffswt_ram.sv
// Simple dual-port memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ffswt_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 64
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/ffswt_word_unit.sv
// Shared map word unit: sets a bit range in one valid word and counts the new bits.
`timescale 1ns / 1ps
`default_nettype none
module ffswt_word_unit (
  input  wire logic [ffswt_pkg::MAP_WORD_W-1:0] old_word,
  input  wire ffswt_pkg::wu_req_t               req,
  output ffswt_pkg::wu_res_t                    res
);

  logic [ffswt_pkg::MAP_WORD_W-1:0] mask;
  logic [ffswt_pkg::MAP_WORD_W-1:0] fresh;

  // Mask of bits lo..hi, then the bits that were not yet valid.
  always_comb begin
    mask  = ({ffswt_pkg::MAP_WORD_W{1'b1}} << req.lo)
          & ({ffswt_pkg::MAP_WORD_W{1'b1}} >> (6'd63 - req.hi));
    fresh = mask & ~old_word;
    res.word  = old_word | mask;
    res.added = ffswt_pkg::ADDED_W'($countones(fresh));
  end

endmodule
`default_nettype wire

// File: hw/rtl/first_fit_segment_write_tracker.sv
// Top level of the first-fit segment write tracker: sequencer, memories and word unit.
//
//   Channel  Ports                     Handshake
//   input    start, busy, in_word      taken when start is high and busy is low
//   result   out_valid, out_word       one-cycle strobe, no back-pressure
//
// An item is taken while idle; the fill-count memory is then scanned from segment 0
// until a segment fits (when none fits, the no-space result follows the scan), a
// preparation step sets up the range, each map word touched is read and written back,
// and a finish step writes the fill count and gives the result; busy stays high till then.
// After reset a clearing pass over every map word zeroes both memories while busy
// stays high.
// The result is shown for exactly one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_segment_write_tracker_defines.svh"
module first_fit_segment_write_tracker #(
  parameter int SEGMENT_BYTES = 1024,
  parameter int SEGMENT_TOTAL = 1024
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire ffswt_pkg::in_t  in_word,
  output logic                 out_valid,
  output ffswt_pkg::out_t      out_word
);

  localparam int WPS       = (SEGMENT_BYTES + 63) / 64;
  localparam int MAP_DEPTH = SEGMENT_TOTAL * WPS;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int SEG_AW    = $clog2(SEGMENT_TOTAL);
  localparam int CNT_W     = $clog2(SEGMENT_BYTES + 1);
  localparam int WIDX_W    = (WPS > 1) ? $clog2(WPS) : 1;
  localparam int SW        = ffswt_pkg::SUM_W;
  localparam int BW        = ffswt_pkg::BIT_IDX_W;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_PREP  = 7'b0001000,
    S_URD   = 7'b0010000,
    S_UWR   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [MAP_AW-1:0]      clr_r, clr_nxt;
  logic [15:0]            off_r, off_nxt;
  logic [15:0]            cnt_r, cnt_nxt;
  logic [SW-1:0]          endc_r, endc_nxt;
  logic [SEG_AW:0]        iss_r, iss_nxt;
  logic                   rdv_r, rdv_nxt;
  logic [SEG_AW:0]        rd_seg_r, rd_seg_nxt;
  logic [SEG_AW-1:0]      seg_r, seg_nxt;
  logic [CNT_W-1:0]       fill_acc_r, fill_acc_nxt;
  logic [MAP_AW-1:0]      base_r, base_nxt;
  logic [WIDX_W-1:0]      w_r, w_nxt;
  logic [WIDX_W-1:0]      first_w_r, first_w_nxt;
  logic [WIDX_W-1:0]      last_w_r, last_w_nxt;
  logic [BW-1:0]          lo_first_r, lo_first_nxt;
  logic [BW-1:0]          hi_last_r, hi_last_nxt;
  logic                   out_valid_r, out_valid_nxt;
  ffswt_pkg::out_t        out_r, out_nxt;

  logic [SW-1:0]          sum_req;
  logic [SW-1:0]          fit_sum;
  logic                   fits;
  logic [SW-1:0]          end_m1;
  logic                   clr_in_fill;

  logic                   map_we;
  logic [MAP_AW-1:0]      map_addr;
  logic [MAP_AW-1:0]      map_waddr;
  logic [ffswt_pkg::MAP_WORD_W-1:0] map_wdata;
  logic [ffswt_pkg::MAP_WORD_W-1:0] map_rdata;
  logic                   fill_we;
  logic [SEG_AW-1:0]      fill_waddr;
  logic [CNT_W-1:0]       fill_wdata;
  logic [CNT_W-1:0]       fill_rdata;

  ffswt_pkg::wu_req_t     wu_req;
  ffswt_pkg::wu_res_t     wu_res;

  // Valid-bit map, one word per 64 bytes of each segment.
  ffswt_ram #(
    .DEPTH (MAP_DEPTH),
    .AW    (MAP_AW),
    .DW    (ffswt_pkg::MAP_WORD_W)
  ) u_map_ram (
    .clk     (clk),
    .we      (map_we),
    .waddr   (map_waddr),
    .wdata   (map_wdata),
    .raddr   (map_addr),
    .rdata_r (map_rdata)
  );

  // Valid byte count per segment.
  ffswt_ram #(
    .DEPTH (SEGMENT_TOTAL),
    .AW    (SEG_AW),
    .DW    (CNT_W)
  ) u_fill_ram (
    .clk     (clk),
    .we      (fill_we),
    .waddr   (fill_waddr),
    .wdata   (fill_wdata),
    .raddr   (iss_r[SEG_AW-1:0]),
    .rdata_r (fill_rdata)
  );

  // Shared word unit, used once per map word of the request.
  ffswt_word_unit u_word_unit (
    .old_word (map_rdata),
    .req      (wu_req),
    .res      (wu_res)
  );

  // Capacity compare and range arithmetic.
  always_comb begin
    sum_req     = SW'(in_word.byte_offset) + SW'(in_word.byte_count);
    fit_sum     = SW'(fill_rdata) + SW'(cnt_r);
    fits        = (fit_sum <= SW'(SEGMENT_BYTES));
    end_m1      = endc_r - SW'(1);
    clr_in_fill = ({1'b0, clr_r} < (MAP_AW+1)'(SEGMENT_TOTAL));
    wu_req.lo   = (w_r == first_w_r) ? lo_first_r : BW'(0);
    wu_req.hi   = (w_r == last_w_r) ? hi_last_r : BW'(63);
  end

  // Memory port selection.
  always_comb begin
    map_addr   = base_r + MAP_AW'(w_r);
    map_we     = 1'b0;
    map_waddr  = map_addr;
    map_wdata  = wu_res.word;
    fill_we    = 1'b0;
    fill_waddr = seg_r;
    fill_wdata = fill_acc_r;
    if (state_r == S_CLEAR) begin
      map_we     = 1'b1;
      map_waddr  = clr_r;
      map_wdata  = '0;
      fill_we    = clr_in_fill;
      fill_waddr = clr_r[SEG_AW-1:0];
      fill_wdata = '0;
    end else if (state_r == S_UWR) begin
      map_we = 1'b1;
    end else if (state_r == S_FIN) begin
      fill_we = 1'b1;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    off_nxt       = off_r;
    cnt_nxt       = cnt_r;
    endc_nxt      = endc_r;
    iss_nxt       = iss_r;
    rdv_nxt       = 1'b0;
    rd_seg_nxt    = iss_r;
    seg_nxt       = seg_r;
    fill_acc_nxt  = fill_acc_r;
    base_nxt      = base_r;
    w_nxt         = w_r;
    first_w_nxt   = first_w_r;
    last_w_nxt    = last_w_r;
    lo_first_nxt  = lo_first_r;
    hi_last_nxt   = hi_last_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + MAP_AW'(1);
        if (clr_r == MAP_AW'(MAP_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          off_nxt   = in_word.byte_offset;
          cnt_nxt   = in_word.byte_count;
          endc_nxt  = (sum_req > SW'(SEGMENT_BYTES)) ? SW'(SEGMENT_BYTES) : sum_req;
          iss_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue one fill-count read a cycle and check the one read before.
        if (iss_r != (SEG_AW+1)'(SEGMENT_TOTAL)) begin
          iss_nxt = iss_r + (SEG_AW+1)'(1);
          rdv_nxt = 1'b1;
        end
        if (rdv_r && fits) begin
          seg_nxt      = rd_seg_r[SEG_AW-1:0];
          fill_acc_nxt = fill_rdata;
          state_nxt    = S_PREP;
        end else if (!rdv_r && (iss_r == (SEG_AW+1)'(SEGMENT_TOTAL))) begin
          out_valid_nxt         = 1'b1;
          out_nxt.status        = ffswt_pkg::STATUS_NO_SPACE;
          out_nxt.segment_index = '0;
          out_nxt.fill_after    = '0;
          state_nxt             = S_IDLE;
        end
      end
      S_PREP: begin
        // Segment base and the first and last map words of the range.
        base_nxt     = MAP_AW'(seg_r) * MAP_AW'(WPS);
        first_w_nxt  = off_r[BW +: WIDX_W];
        last_w_nxt   = end_m1[BW +: WIDX_W];
        lo_first_nxt = off_r[BW-1:0];
        hi_last_nxt  = end_m1[BW-1:0];
        w_nxt        = off_r[BW +: WIDX_W];
        if (endc_r <= SW'(off_r)) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_URD;
        end
      end
      S_URD: begin
        state_nxt = S_UWR;
      end
      S_UWR: begin
        fill_acc_nxt = fill_acc_r + CNT_W'(wu_res.added);
        if (w_r == last_w_r) begin
          state_nxt = S_FIN;
        end else begin
          w_nxt     = w_r + WIDX_W'(1);
          state_nxt = S_URD;
        end
      end
      S_FIN: begin
        out_valid_nxt         = 1'b1;
        out_nxt.status        = ffswt_pkg::STATUS_WRITTEN;
        out_nxt.segment_index = 10'(seg_r);
        out_nxt.fill_after    = 11'(fill_acc_r);
        state_nxt             = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      iss_r       <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      iss_r       <= iss_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    off_r      <= off_nxt;
    cnt_r      <= cnt_nxt;
    endc_r     <= endc_nxt;
    rd_seg_r   <= rd_seg_nxt;
    seg_r      <= seg_nxt;
    fill_acc_r <= fill_acc_nxt;
    base_r     <= base_nxt;
    w_r        <= w_nxt;
    first_w_r  <= first_w_nxt;
    last_w_r   <= last_w_nxt;
    lo_first_r <= lo_first_nxt;
    hi_last_r  <= hi_last_nxt;
    out_r      <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // Checks on the sequencer and the result word.
  `FFSWT_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid, !out_valid, "result strobe longer than one cycle")
  `FFSWT_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy && !out_valid, "accepted word did not make the block busy")
  `FFSWT_ASSERT_IMP(a_no_space_zero, clk, rst_n, out_valid && out_word.status, out_word.segment_index == 10'd0 && out_word.fill_after == 11'd0, "no-space result carries non-zero fields")
  `FFSWT_ASSERT_IMP(a_fill_bound, clk, rst_n, state_r == S_UWR, fill_acc_r <= CNT_W'(SEGMENT_BYTES), "fill count above segment capacity")

endmodule
`default_nettype wire

// File: bench/segment_write_checker.sv
// Checker for the segment write tracker: predicts each outcome and compares the result words.
`timescale 1ns / 1ps
module segment_write_checker #(
  parameter int SEG_BYTES = 1024,
  parameter int SEG_TOTAL = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            busy,
  input  ffswt_pkg::in_t  in_word,
  input  logic            out_valid,
  input  ffswt_pkg::out_t out_word,
  output int              mismatch_count,
  output int              outcomes_waiting
);

  // Our own copy of the byte-valid maps and fill counts.
  bit [SEG_BYTES-1:0] seg_valid [SEG_TOTAL];
  int                 seg_fill  [SEG_TOTAL];

  // Outcomes of accepted requests whose result word has not yet been seen.
  ffswt_pkg::out_t expected_outcomes [$];
  ffswt_pkg::out_t oldest;

  // First-fit placement of one write request, updating our maps and counts.
  function automatic ffswt_pkg::out_t place_request(input ffswt_pkg::in_t req);
    ffswt_pkg::out_t res;
    int              seg;
    int              stop;
    res = '0;
    seg = -1;
    for (int s = 0; s < SEG_TOTAL; s++) begin
      if (seg < 0 && seg_fill[s] + int'(req.byte_count) <= SEG_BYTES) seg = s;
    end
    if (seg < 0) begin
      // Nothing fits: status only, the state is left alone.
      res.status = ffswt_pkg::STATUS_NO_SPACE;
    end else begin
      // Positions at or past the segment end are dropped.
      stop = int'(req.byte_offset) + int'(req.byte_count);
      if (stop > SEG_BYTES) stop = SEG_BYTES;
      for (int p = int'(req.byte_offset); p < stop; p++) begin
        if (!seg_valid[seg][p]) begin
          seg_valid[seg][p] = 1'b1;
          seg_fill[seg]++;
        end
      end
      res.status        = ffswt_pkg::STATUS_WRITTEN;
      res.segment_index = 10'(seg);
      res.fill_after    = 11'(seg_fill[seg]);
    end
    return res;
  endfunction

  initial begin
    mismatch_count   = 0;
    outcomes_waiting = 0;
  end

  // Results are compared before a request taken at the same edge is predicted.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SEG_TOTAL; s++) begin
        seg_valid[s] = '0;
        seg_fill[s]  = 0;
      end
      expected_outcomes.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (expected_outcomes.size() == 0) begin
          $error("result word with no write request outstanding: %h", out_word);
          mismatch_count++;
        end else begin
          oldest = expected_outcomes.pop_front();
          if (out_word.status !== oldest.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   oldest.status, out_word.status);
            mismatch_count++;
          end
          if (out_word.segment_index !== oldest.segment_index) begin
            $error("segment_index mismatch: expected %0d, actual %0d",
                   oldest.segment_index, out_word.segment_index);
            mismatch_count++;
          end
          if (out_word.fill_after !== oldest.fill_after) begin
            $error("fill_after mismatch: expected %0d, actual %0d",
                   oldest.fill_after, out_word.fill_after);
            mismatch_count++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) expected_outcomes.push_back(place_request(in_word));
    end
    outcomes_waiting = expected_outcomes.size();
  end

endmodule

// File: bench/tb_first_fit_segment_write_tracker.sv
// Testbench top for the segment write tracker: clock, reset, write-request stimulus and verdict.
`timescale 1ns / 1ps
module tb_first_fit_segment_write_tracker;

  localparam int SEG_BYTES    = 1024;
  localparam int SEG_TOTAL    = 1024;
  localparam int RANDOM_WORDS = 1530;
  // The limit allows for the slowest legal run: every request scanning all
  // segments, touching sixteen map words and waiting the longest gap, plus the
  // clearing pass after reset.
  localparam int CYCLE_LIMIT  = 6_000_000;
  localparam int TAIL_CYCLES  = 64;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  ffswt_pkg::in_t  in_word;
  logic            out_valid;
  ffswt_pkg::out_t out_word;
  int              mismatch_count;
  int              outcomes_waiting;
  int              cycle_count;
  int              gap_max;

  first_fit_segment_write_tracker #(
    .SEGMENT_BYTES (SEG_BYTES),
    .SEGMENT_TOTAL (SEG_TOTAL)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  segment_write_checker #(
    .SEG_BYTES (SEG_BYTES),
    .SEG_TOTAL (SEG_TOTAL)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_word          (in_word),
    .out_valid        (out_valid),
    .out_word         (out_word),
    .mismatch_count   (mismatch_count),
    .outcomes_waiting (outcomes_waiting)
  );

  // Free-running clock, 8 ns period.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung block ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Drive one write request and hold it until the block takes it.
  task automatic send_write(input logic [15:0] offset, input logic [15:0] count);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start               <= 1'b1;
    in_word.byte_offset <= offset;
    in_word.byte_count  <= count;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (outcomes_waiting != 0) @(negedge clk);
  endtask

  // One random request, weighted towards small writes that fill segments gradually.
  task automatic send_random_write();
    int          pick;
    logic [15:0] offset;
    logic [15:0] count;
    pick = $urandom_range(0, 99);
    if (pick < 58) begin
      offset = 16'($urandom_range(0, SEG_BYTES - 1));
      count  = 16'($urandom_range(1, 64));
    end else if (pick < 68) begin
      offset = 16'($urandom_range(0, SEG_BYTES - 1));
      count  = 16'($urandom_range(65, SEG_BYTES));
    end else if (pick < 76) begin
      // Starts past the segment end, so nothing is marked.
      offset = 16'($urandom_range(SEG_BYTES, 65535));
      count  = 16'($urandom_range(0, SEG_BYTES));
    end else if (pick < 82) begin
      offset = 16'($urandom_range(0, 65535));
      count  = '0;
    end else if (pick < 87) begin
      // Larger than any segment: never fits.
      offset = 16'($urandom_range(0, 65535));
      count  = 16'($urandom_range(SEG_BYTES + 1, 65535));
    end else if (pick < 96) begin
      // Near the segment end, often running over it.
      offset = 16'($urandom_range(SEG_BYTES - 64, SEG_BYTES - 1));
      count  = 16'($urandom_range(1, 128));
    end else begin
      offset = 16'($urandom_range(0, 65535));
      count  = 16'($urandom_range(0, 65535));
    end
    send_write(offset, count);
  endtask

  // Reset, directed requests, random requests, then the verdict.
  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_word = '0;
    gap_max = 8;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: empty writes, overlaps, the segment end and no room.
    send_write(16'd0, 16'd0);
    send_write(16'd0, 16'd1);
    send_write(16'd0, 16'd1);
    send_write(16'd1023, 16'd1);
    send_write(16'd1020, 16'd10);
    send_write(16'd1024, 16'd5);
    send_write(16'hFFFF, 16'd3);
    send_write(16'd0, 16'd1019);
    send_write(16'd0, 16'd5);
    send_write(16'd1019, 16'd4);
    send_write(16'd500, 16'd0);
    send_write(16'd0, 16'hFFFF);
    send_write(16'd0, 16'd1025);
    send_write(16'd0, 16'd1024);
    send_write(16'hAAAA, 16'd1024);
    send_write(16'h5555, 16'h02AA);
    send_write(16'd64, 16'd64);
    send_write(16'd63, 16'd2);
    send_write(16'd1, 16'd3);
    send_write(16'd1023, 16'hFFFF);
    send_write(16'hFFFF, 16'hFFFF);
    drain_results();

    // Random part, with stretches of back-to-back words and occasional drains.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 64 == 0) gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      if ($urandom_range(0, 199) == 0) drain_results();
      send_random_write();
    end
    start <= 1'b0;

    // Wait for the last results, then watch a little longer for strays.
    while (outcomes_waiting != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outcomes_waiting == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
